[rtl/adst_pkg.sv]
// ============================================================================
// adst_pkg: shared constants and types of the anisotropic diffusion stencil
// Widths of the sample path, register codes and the bundles passed between
// the window, arithmetic and output parts of the block.
// ============================================================================
package adst_pkg;

    localparam int MAX_ROW_LENGTH = 512;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 18;
    localparam int OUT_WIDTH      = 40;
    localparam int MAX_ROW_COUNT  = 4096;

    // Column and row counters only ever hold positions inside the grid.
    localparam int COL_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int ROW_W = $clog2(MAX_ROW_COUNT);

    // Register field widths as written through the configuration port.
    localparam int LEN_W      = 10;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_WIDTH;

    // Pre-added neighbor pairs and the folded centre weight -(2a+2b).
    localparam int PAIR_W        = SAMPLE_WIDTH + 1;
    localparam int DIFF_W        = SAMPLE_WIDTH + 2;
    localparam int CENTER_COEF_W = COEF_WIDTH + 3;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = FIFO_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_AXIAL_ROW    = 3'd0,
        REG_COEF_AXIAL_COL    = 3'd1,
        REG_COEF_CROSS        = 3'd2,
        REG_PADDED_ROW_LENGTH = 3'd3,
        REG_PADDED_ROW_COUNT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0]    axial_row;
        logic signed [COEF_WIDTH-1:0]    axial_col;
        logic signed [COEF_WIDTH-1:0]    diag;
        logic signed [CENTER_COEF_W-1:0] center;
    } coef_t;

    typedef struct packed {
        logic [COL_W-1:0] len_m1;
        logic [ROW_W-1:0] rows_m1;
    } geom_t;

    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic signed [SAMPLE_WIDTH-1:0] center;
        logic signed [PAIR_W-1:0]       row_pair;
        logic signed [PAIR_W-1:0]       col_pair;
        logic signed [DIFF_W-1:0]       diag_diff;
    } taps_t;

endpackage

[rtl/adst_window.sv]
// ============================================================================
// adst_window: line stores, 3x3 window and raster position counters
// Each accepted sample reads both line stores at its column, shifts the
// window one column on the next cycle and writes the column back. The
// window's neighbor pairs are pre-added for the arithmetic stages.
// ============================================================================
module adst_window (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    sample_fire,
    input  logic signed [adst_pkg::SAMPLE_WIDTH-1:0] sample,
    input  adst_pkg::geom_t                         geom,
    output logic                                    emit_now,
    output adst_pkg::taps_t                         taps
);
    import adst_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] upper_mem  [MAX_ROW_LENGTH];
    logic signed [SAMPLE_WIDTH-1:0] middle_mem [MAX_ROW_LENGTH];

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic                           v1_reg;
    logic                           emit1_reg;
    logic                           last1_reg;
    logic [COL_W-1:0]               col1_reg;
    logic signed [SAMPLE_WIDTH-1:0] samp1_reg;
    logic signed [SAMPLE_WIDTH-1:0] up_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] mid_rd_reg;

    logic signed [SAMPLE_WIDTH-1:0] win_reg [3][3];

    taps_t taps_reg, taps_next;

    logic col_wrap;
    logic last_now;

    assign col_wrap = (col_reg >= geom.len_m1);
    assign emit_now = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign last_now = (row_reg >= geom.rows_m1) && col_wrap;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap) begin
            col_next = '0;
            row_next = (row_reg >= geom.rows_m1) ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (sample_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Consecutive samples always sit in different columns, so the write-back
    // of one sample never collides with the read of the next.
    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            up_rd_reg  <= upper_mem[col_reg];
            mid_rd_reg <= middle_mem[col_reg];
        end
        if (v1_reg) begin
            upper_mem[col1_reg]  <= mid_rd_reg;
            middle_mem[col1_reg] <= samp1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= sample_fire;
        end
        if (sample_fire) begin
            emit1_reg <= emit_now;
            last1_reg <= last_now;
            col1_reg  <= col_reg;
            samp1_reg <= sample;
        end
    end

    // Pairs are formed from the window as it will be after this shift.
    always_comb begin
        taps_next.valid     = v1_reg && emit1_reg;
        taps_next.last      = last1_reg;
        taps_next.center    = win_reg[1][2];
        taps_next.row_pair  = PAIR_W'(win_reg[0][2]) + PAIR_W'(win_reg[2][2]);
        taps_next.col_pair  = PAIR_W'(win_reg[1][1]) + PAIR_W'(mid_rd_reg);
        taps_next.diag_diff = DIFF_W'(win_reg[0][1]) + DIFF_W'(samp1_reg)
                            - DIFF_W'(up_rd_reg) - DIFF_W'(win_reg[2][1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
            taps_reg.valid <= 1'b0;
        end else begin
            if (v1_reg) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= up_rd_reg;
                win_reg[1][2] <= mid_rd_reg;
                win_reg[2][2] <= samp1_reg;
            end
            taps_reg.valid <= taps_next.valid;
        end
        taps_reg.last      <= taps_next.last;
        taps_reg.center    <= taps_next.center;
        taps_reg.row_pair  <= taps_next.row_pair;
        taps_reg.col_pair  <= taps_next.col_pair;
        taps_reg.diag_diff <= taps_next.diag_diff;
    end

    assign taps = taps_reg;

endmodule

[rtl/adst_mac.sv]
// ============================================================================
// adst_mac: weighted stencil sum
// Four registered products of weights and neighbor pairs, then a two-level
// registered adder tree that yields the Q15.24 diffusion term.
// ============================================================================
module adst_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  adst_pkg::taps_t                       taps,
    input  adst_pkg::coef_t                       coef,
    output logic                                  push,
    output logic signed [adst_pkg::OUT_WIDTH-1:0] push_term,
    output logic                                  push_last
);
    import adst_pkg::*;

    localparam int CENTER_PROD_W = CENTER_COEF_W + SAMPLE_WIDTH;
    localparam int PAIR_PROD_W   = COEF_WIDTH + PAIR_W;
    localparam int DIFF_PROD_W   = COEF_WIDTH + DIFF_W;

    logic                             p_valid_reg;
    logic                             p_last_reg;
    logic signed [CENTER_PROD_W-1:0]  p_center_reg;
    logic signed [PAIR_PROD_W-1:0]    p_row_reg;
    logic signed [PAIR_PROD_W-1:0]    p_col_reg;
    logic signed [DIFF_PROD_W-1:0]    p_diag_reg;

    logic                             s_valid_reg;
    logic                             s_last_reg;
    logic signed [OUT_WIDTH-1:0]      sum_a_reg;
    logic signed [OUT_WIDTH-1:0]      sum_b_reg;

    logic                             f_valid_reg;
    logic                             f_last_reg;
    logic signed [OUT_WIDTH-1:0]      term_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= taps.valid;
            s_valid_reg <= p_valid_reg;
            f_valid_reg <= s_valid_reg;
        end
        p_last_reg   <= taps.last;
        p_center_reg <= taps.center * coef.center;
        p_row_reg    <= taps.row_pair * coef.axial_row;
        p_col_reg    <= taps.col_pair * coef.axial_col;
        p_diag_reg   <= taps.diag_diff * coef.diag;

        s_last_reg   <= p_last_reg;
        sum_a_reg    <= OUT_WIDTH'(p_center_reg) + OUT_WIDTH'(p_row_reg);
        sum_b_reg    <= OUT_WIDTH'(p_col_reg) + OUT_WIDTH'(p_diag_reg);

        f_last_reg   <= s_last_reg;
        term_reg     <= sum_a_reg + sum_b_reg;
    end

    assign push      = f_valid_reg;
    assign push_term = term_reg;
    assign push_last = f_last_reg;

endmodule

[rtl/adst_out_fifo.sv]
// ============================================================================
// adst_out_fifo: result queue
// Decouples the arithmetic pipeline from the result channel; the top level
// only accepts a sample while a slot is reserved for its result.
// ============================================================================
module adst_out_fifo (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  push,
    input  logic signed [adst_pkg::OUT_WIDTH-1:0] push_term,
    input  logic                                  push_last,
    input  logic                                  pop,
    output logic                                  out_valid,
    output logic signed [adst_pkg::OUT_WIDTH-1:0] out_term,
    output logic                                  out_last
);
    import adst_pkg::*;

    logic signed [OUT_WIDTH-1:0] term_mem [FIFO_DEPTH];
    logic                        last_mem [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0]      count_reg, count_next;
    logic                  do_pop;

    assign out_valid = (count_reg != '0);
    assign do_pop    = pop && out_valid;
    assign out_term  = term_mem[rd_ptr_reg];
    assign out_last  = last_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + OCC_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            term_mem[wr_ptr_reg] <= push_term;
            last_mem[wr_ptr_reg] <= push_last;
        end
    end

endmodule

[rtl/anisotropic_diffusion_stencil.sv]
// ============================================================================
// anisotropic_diffusion_stencil: nine-point anisotropic diffusion term
// Streams a ghost-padded Q7.8 voltage grid in raster order and emits one
// Q15.24 stencil sum per interior centre, flagging the last one.
//
//   channel  direction  payload                          transaction
//   s_       in         vm_sample                        s_valid & s_ready
//   m_       out        diffusion_term, last_cell        m_valid & m_ready
//   cfg_     in         cfg_index, cfg_data              cfg_valid & cfg_ready
//
// One sample is taken every cycle while s_ready is high; the two line
// stores are read and written once per sample, which sets that rate.
// A sample completing a result passes the window and tap registers, the
// product, sum and term registers and the queue before m_valid rises.
// Synchronous reset clears counters, window and queue; the line stores
// hold no reset value and are filled by the first two rows of a frame.
// s_ready drops only while eight results are queued or in flight.
// ============================================================================
module anisotropic_diffusion_stencil (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [adst_pkg::SAMPLE_WIDTH-1:0] s_vm_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [adst_pkg::OUT_WIDTH-1:0]    m_diffusion_term,
    output logic                                     m_last_cell,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [adst_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [adst_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import adst_pkg::*;

    function automatic logic [COL_W-1:0] len_to_last(input logic [LEN_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 3) begin
            n = 3;
        end else if (n > MAX_ROW_LENGTH) begin
            n = MAX_ROW_LENGTH;
        end
        return COL_W'(n - 1);
    endfunction

    function automatic logic [ROW_W-1:0] cnt_to_last(input logic [CNT_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 3) begin
            n = 3;
        end else if (n > MAX_ROW_COUNT) begin
            n = MAX_ROW_COUNT;
        end
        return ROW_W'(n - 1);
    endfunction

    coef_t coef_reg;
    geom_t geom_reg;
    logic signed [CENTER_COEF_W-1:0] center_next;

    logic             s_fire;
    logic             m_fire;
    logic             emit_now;
    logic [OCC_W-1:0] occ_reg, occ_next;

    taps_t                       taps;
    logic                        push;
    logic signed [OUT_WIDTH-1:0] push_term;
    logic                        push_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = (occ_reg < OCC_W'(FIFO_DEPTH));
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;

    // The centre weight -(2a+2b) follows the axial weights in the next cycle.
    assign center_next = -((CENTER_COEF_W'(coef_reg.axial_row)
                          + CENTER_COEF_W'(coef_reg.axial_col)) <<< 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.axial_row <= '0;
            coef_reg.axial_col <= '0;
            coef_reg.diag      <= '0;
            coef_reg.center    <= '0;
            geom_reg.len_m1    <= len_to_last(LEN_W'(258));
            geom_reg.rows_m1   <= cnt_to_last(CNT_W'(258));
        end else begin
            coef_reg.center <= center_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_COEF_AXIAL_ROW: begin
                        coef_reg.axial_row <= $signed(cfg_data[COEF_WIDTH-1:0]);
                    end
                    REG_COEF_AXIAL_COL: begin
                        coef_reg.axial_col <= $signed(cfg_data[COEF_WIDTH-1:0]);
                    end
                    REG_COEF_CROSS: begin
                        coef_reg.diag <= $signed(cfg_data[COEF_WIDTH-1:0]);
                    end
                    REG_PADDED_ROW_LENGTH: begin
                        geom_reg.len_m1 <= len_to_last(cfg_data[LEN_W-1:0]);
                    end
                    REG_PADDED_ROW_COUNT: begin
                        geom_reg.rows_m1 <= cnt_to_last(cfg_data[CNT_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Every result-producing sample reserves a queue slot when it is taken.
    always_comb begin
        occ_next = occ_reg;
        if ((s_fire && emit_now) && !m_fire) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (!(s_fire && emit_now) && m_fire) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    adst_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_fire (s_fire),
        .sample      (s_vm_sample),
        .geom        (geom_reg),
        .emit_now    (emit_now),
        .taps        (taps)
    );

    adst_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .taps      (taps),
        .coef      (coef_reg),
        .push      (push),
        .push_term (push_term),
        .push_last (push_last)
    );

    adst_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_term (push_term),
        .push_last (push_last),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_term  (m_diffusion_term),
        .out_last  (m_last_cell)
    );

endmodule

[rtl/adst_checker.sv]
// ============================================================================
// adst_checker: port-level checks of the diffusion stencil
// Watches reset state, result hold under back-pressure, input throttling
// and pipeline latency as seen on the top-level ports.
// ============================================================================
module adst_checker (
    input logic                                     aclk,
    input logic                                     aresetn,
    input logic                                     s_valid,
    input logic                                     s_ready,
    input logic                                     m_valid,
    input logic                                     m_ready,
    input logic signed [adst_pkg::OUT_WIDTH-1:0]    m_diffusion_term,
    input logic                                     m_last_cell
);
    import adst_pkg::*;

    localparam int RESULT_LATENCY = 6;

    // Coming out of reset the block is empty and ready for samples.
    assert property (@(posedge aclk) !aresetn |=> s_ready && !m_valid)
        else $error("block not empty after reset");

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_diffusion_term)
                                && $stable(m_last_cell))
        else $error("stalled result changed");

    // The pipeline never holds all reserved slots, so throttling means results wait.
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("input throttled with no result waiting");

    // A result can only show up a fixed latency after a sample transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, RESULT_LATENCY))
        else $error("result without matching sample");

endmodule

bind anisotropic_diffusion_stencil adst_checker u_adst_checker (.*);
